### sv/fast_inverse_square_root_core_macros.svh
// Assertion macros for the inverse square root core.
`ifndef FAST_INVERSE_SQUARE_ROOT_CORE_MACROS_SVH
`define FAST_INVERSE_SQUARE_ROOT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FISR_ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("fisr assertion failed");
`define FISR_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("fisr assertion failed");
`else
`define FISR_ASSERT_IMPLIES(label, clk, rst, a, b)
`define FISR_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

### sv/fisr_pkg.sv
`default_nettype none
package fisr_pkg;
   localparam logic [31:0] MAGIC_CONST  = 32'h5f3759df;
   localparam logic [31:0] ONE_HALF     = 32'h3f000000;
   localparam logic [31:0] THREE_HALVES = 32'h3fc00000;
   localparam logic [31:0] DEFAULT_NAN  = 32'hffc00000;
   localparam logic [31:0] QUIET_BIT    = 32'h00400000;

   typedef struct packed {
      logic        valid;
      logic [31:0] side;
   } tag_type;

   function automatic logic [5:0] lzc32(input logic [31:0] v);
      logic [5:0] n;
      logic       found;
      n = 6'd0;
      found = 1'b0;
      for (int i = 31; i >= 0; i--) begin
         if (!found && v[i]) begin
            found = 1'b1;
         end else if (!found) begin
            n = n + 6'd1;
         end
      end
      return n;
   endfunction
endpackage
`default_nettype wire

### sv/fast_inverse_square_root_core.sv
// Fast inverse square root core, one Newton step, IEEE single precision.
// Input channel req_valid/req_ready carries req_x_bits, the raw float pattern.
// Result channel rsp_valid/rsp_ready carries rsp_result_bits, the raw estimate.
// Each item yields exactly one result item, in order.
// Pipeline: three float multiplies of 3 stages each, one subtract of 4 stages,
// and a final multiply of 3 stages, 16 register stages in all.
// Throughput is one item per cycle while the output is not held; the whole pipe advances together.
// When rsp_valid is high and rsp_ready is low, every stage holds and req_ready
// drops; nothing is lost or repeated, and flow resumes once the item is taken.
// Reset clears all stage valid bits; the pipe comes up empty and ready.
`default_nettype none
`include "fast_inverse_square_root_core_macros.svh"
module fast_inverse_square_root_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_x_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_result_bits
);
   import fisr_pkg::*;

   logic        en;
   tag_type     tag0, tag_h, tag_t1, tag_t2, tag_t3, tag_r;
   logic [31:0] y0, xhalf, t1, t2, t3, r;

   assign en = !tag_r.valid || rsp_ready;
   assign req_ready = en;

   assign y0 = MAGIC_CONST - {req_x_bits[31], req_x_bits[31:1]};
   assign tag0 = '{valid: req_valid && en, side: y0};

   fisr_fmul u_half (
      .clock(clock), .reset(reset), .en(en), .in_tag(tag0),
      .a(ONE_HALF), .b(req_x_bits), .out_tag(tag_h), .result(xhalf));

   fisr_fmul u_t1 (
      .clock(clock), .reset(reset), .en(en), .in_tag(tag_h),
      .a(xhalf), .b(tag_h.side), .out_tag(tag_t1), .result(t1));

   fisr_fmul u_t2 (
      .clock(clock), .reset(reset), .en(en), .in_tag(tag_t1),
      .a(t1), .b(tag_t1.side), .out_tag(tag_t2), .result(t2));

   fisr_fsub u_t3 (
      .clock(clock), .reset(reset), .en(en), .in_tag(tag_t2),
      .a(THREE_HALVES), .b(t2), .out_tag(tag_t3), .result(t3));

   fisr_fmul u_r (
      .clock(clock), .reset(reset), .en(en), .in_tag(tag_t3),
      .a(tag_t3.side), .b(t3), .out_tag(tag_r), .result(r));

   assign rsp_valid = tag_r.valid;
   assign rsp_result_bits = r;

   `FISR_ASSERT_IMPLIES(a_ready_when_drained, clock, reset, rsp_ready || !rsp_valid, req_ready)
   `FISR_ASSERT_NEXT(a_empty_after_reset, clock, 1'b0, reset, !rsp_valid)
   `FISR_ASSERT_NEXT(a_hold_blocks_input, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule
`default_nettype wire

### sv/fisr_fmul.sv
`default_nettype none
module fisr_fmul (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire fisr_pkg::tag_type in_tag,
   input  wire logic [31:0]      a,
   input  wire logic [31:0]      b,
   output fisr_pkg::tag_type     out_tag,
   output logic [31:0]           result
);
   import fisr_pkg::*;

   // stage 1: unpack, normalize subnormal operands, special values
   logic              sa, sb;
   logic [7:0]        xa, xb;
   logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [23:0]       ma, mb;
   logic [5:0]        lza, lzb;
   logic signed [10:0] ea, eb;
   logic              spec1_in;
   logic [31:0]       specv1_in;

   always_comb begin
      sa = a[31];
      sb = b[31];
      xa = a[30:23];
      xb = b[30:23];
      a_nan  = (&xa) && (|a[22:0]);
      b_nan  = (&xb) && (|b[22:0]);
      a_inf  = (&xa) && !(|a[22:0]);
      b_inf  = (&xb) && !(|b[22:0]);
      a_zero = (xa == 8'd0) && !(|a[22:0]);
      b_zero = (xb == 8'd0) && !(|b[22:0]);
      ma = {xa != 8'd0, a[22:0]};
      mb = {xb != 8'd0, b[22:0]};
      lza = lzc32({ma, 8'hff});
      lzb = lzc32({mb, 8'hff});
      ea = ((xa == 8'd0) ? -11'sd126 : ($signed({3'b000, xa}) - 11'sd127))
           - $signed({5'b00000, lza});
      eb = ((xb == 8'd0) ? -11'sd126 : ($signed({3'b000, xb}) - 11'sd127))
           - $signed({5'b00000, lzb});
      spec1_in  = 1'b1;
      specv1_in = 32'd0;
      priority if (a_nan) begin
         specv1_in = a | QUIET_BIT;
      end else if (b_nan) begin
         specv1_in = b | QUIET_BIT;
      end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
         specv1_in = DEFAULT_NAN;
      end else if (a_inf || b_inf) begin
         specv1_in = {sa ^ sb, 8'hff, 23'd0};
      end else if (a_zero || b_zero) begin
         specv1_in = {sa ^ sb, 31'd0};
      end else begin
         spec1_in = 1'b0;
      end
   end

   tag_type            tag1_ff, tag2_ff, tag3_ff;
   logic               s1_ff, s2_ff;
   logic [23:0]        ma1_ff, mb1_ff;
   logic signed [10:0] e1_ff, e2_ff;
   logic               spec1_ff, spec2_ff;
   logic [31:0]        specv1_ff, specv2_ff;
   logic [47:0]        p2_ff;
   logic [31:0]        res3_ff;

   // stage 3: normalize, denormalize, round
   logic [47:0]        pn;
   logic signed [10:0] ebias;
   logic [5:0]         sh;
   logic [47:0]        shifted, mask;
   logic [23:0]        mant;
   logic               g, st, up;
   logic [7:0]         efield;
   logic [30:0]        word;
   logic [31:0]        res3_in;

   always_comb begin
      if (p2_ff[47]) begin
         pn = p2_ff;
         ebias = e2_ff + 11'sd128;
      end else begin
         pn = {p2_ff[46:0], 1'b0};
         ebias = e2_ff + 11'sd127;
      end
      if (ebias >= 11'sd1) begin
         sh = 6'd0;
      end else if (ebias < -11'sd24) begin
         sh = 6'd26;
      end else begin
         sh = 6'(11'sd1 - ebias);
      end
      shifted = pn >> sh;
      mask = (48'd1 << sh) - 48'd1;
      mant = shifted[47:24];
      g = shifted[23];
      st = (|shifted[22:0]) || (|(pn & mask));
      up = g && (st || mant[0]);
      efield = (ebias >= 11'sd1) ? ebias[7:0] : 8'd0;
      word = {efield, mant[22:0]} + {30'd0, up};
      if (spec2_ff) begin
         res3_in = specv2_ff;
      end else if (ebias >= 11'sd255) begin
         res3_in = {s2_ff, 8'hff, 23'd0};
      end else begin
         res3_in = {s2_ff, word};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
      end else if (en) begin
         tag1_ff.valid <= in_tag.valid;
         tag2_ff.valid <= tag1_ff.valid;
         tag3_ff.valid <= tag2_ff.valid;
      end
      if (en) begin
         tag1_ff.side <= in_tag.side;
         s1_ff        <= sa ^ sb;
         ma1_ff       <= ma << lza;
         mb1_ff       <= mb << lzb;
         e1_ff        <= ea + eb;
         spec1_ff     <= spec1_in;
         specv1_ff    <= specv1_in;
         tag2_ff.side <= tag1_ff.side;
         s2_ff        <= s1_ff;
         p2_ff        <= ma1_ff * mb1_ff;
         e2_ff        <= e1_ff;
         spec2_ff     <= spec1_ff;
         specv2_ff    <= specv1_ff;
         tag3_ff.side <= tag2_ff.side;
         res3_ff      <= res3_in;
      end
   end

   assign out_tag = tag3_ff;
   assign result  = res3_ff;
endmodule
`default_nettype wire

### sv/fisr_fsub.sv
`default_nettype none
module fisr_fsub (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire fisr_pkg::tag_type in_tag,
   input  wire logic [31:0]      a,
   input  wire logic [31:0]      b,
   output fisr_pkg::tag_type     out_tag,
   output logic [31:0]           result
);
   import fisr_pkg::*;

   // stage 1: unpack a and -b, order by magnitude, align
   logic [31:0] nb, big, sml;
   logic        a_nan, b_nan, a_inf, b_inf;
   logic [7:0]  eb_big, eb_sml, d;
   logic [4:0]  sh;
   logic [26:0] mbig, msml, t, mask;
   logic        spec1_in;
   logic [31:0] specv1_in;

   always_comb begin
      nb = {~b[31], b[30:0]};
      a_nan = (&a[30:23]) && (|a[22:0]);
      b_nan = (&b[30:23]) && (|b[22:0]);
      a_inf = (&a[30:23]) && !(|a[22:0]);
      b_inf = (&b[30:23]) && !(|b[22:0]);
      if (a[30:0] >= b[30:0]) begin
         big = a;
         sml = nb;
      end else begin
         big = nb;
         sml = a;
      end
      eb_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      eb_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      d = eb_big - eb_sml;
      sh = (d > 8'd27) ? 5'd27 : d[4:0];
      mbig = {big[30:23] != 8'd0, big[22:0], 3'b000};
      msml = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
      t = msml >> sh;
      mask = (27'd1 << sh) - 27'd1;
      spec1_in = 1'b1;
      specv1_in = 32'd0;
      priority if (a_nan) begin
         specv1_in = a | QUIET_BIT;
      end else if (b_nan) begin
         specv1_in = b | QUIET_BIT;
      end else if (a_inf && b_inf && (a[31] != nb[31])) begin
         specv1_in = DEFAULT_NAN;
      end else if (a_inf) begin
         specv1_in = a;
      end else if (b_inf) begin
         specv1_in = nb;
      end else begin
         spec1_in = 1'b0;
      end
   end

   tag_type     tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic        s1_ff, s2_ff, s3_ff;
   logic        sub1_ff;
   logic [7:0]  e1_ff, e2_ff;
   logic [26:0] mb1_ff, ms1_ff;
   logic [27:0] sum2_ff;
   logic [26:0] n3_ff;
   logic [8:0]  ef3_ff;
   logic        spec1_ff, spec2_ff, spec3_ff;
   logic [31:0] specv1_ff, specv2_ff, specv3_ff;
   logic [31:0] res4_ff;

   // stage 3: normalize
   logic [5:0]  lz;
   logic [8:0]  k;
   logic [26:0] n3_in;
   logic [8:0]  ef3_in;
   logic        s3_in;

   always_comb begin
      lz = lzc32({sum2_ff[26:0], 5'h1f});
      k = 9'd0;
      if (sum2_ff[27]) begin
         n3_in = {sum2_ff[27:2], sum2_ff[1] | sum2_ff[0]};
         ef3_in = {1'b0, e2_ff} + 9'd1;
      end else begin
         k = ({3'd0, lz} < {1'b0, e2_ff}) ? {3'd0, lz} : ({1'b0, e2_ff} - 9'd1);
         n3_in = sum2_ff[26:0] << k;
         ef3_in = n3_in[26] ? ({1'b0, e2_ff} - k) : 9'd0;
      end
      s3_in = (sum2_ff == 28'd0) ? 1'b0 : s2_ff;
   end

   // stage 4: round
   logic        up;
   logic [30:0] word;
   logic [31:0] res4_in;

   always_comb begin
      up = n3_ff[2] && ((|n3_ff[1:0]) || n3_ff[3]);
      word = {ef3_ff[7:0], n3_ff[25:3]} + {30'd0, up};
      if (spec3_ff) begin
         res4_in = specv3_ff;
      end else if (ef3_ff >= 9'd255) begin
         res4_in = {s3_ff, 8'hff, 23'd0};
      end else begin
         res4_in = {s3_ff, word};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
         tag4_ff.valid <= 1'b0;
      end else if (en) begin
         tag1_ff.valid <= in_tag.valid;
         tag2_ff.valid <= tag1_ff.valid;
         tag3_ff.valid <= tag2_ff.valid;
         tag4_ff.valid <= tag3_ff.valid;
      end
      if (en) begin
         tag1_ff.side <= in_tag.side;
         s1_ff        <= big[31];
         sub1_ff      <= big[31] ^ sml[31];
         e1_ff        <= eb_big;
         mb1_ff       <= mbig;
         ms1_ff       <= {t[26:1], t[0] | (|(msml & mask))};
         spec1_ff     <= spec1_in;
         specv1_ff    <= specv1_in;
         tag2_ff.side <= tag1_ff.side;
         s2_ff        <= s1_ff;
         e2_ff        <= e1_ff;
         sum2_ff      <= sub1_ff ? ({1'b0, mb1_ff} - {1'b0, ms1_ff})
                                 : ({1'b0, mb1_ff} + {1'b0, ms1_ff});
         spec2_ff     <= spec1_ff;
         specv2_ff    <= specv1_ff;
         tag3_ff.side <= tag2_ff.side;
         s3_ff        <= s3_in;
         n3_ff        <= n3_in;
         ef3_ff       <= ef3_in;
         spec3_ff     <= spec2_ff;
         specv3_ff    <= specv2_ff;
         tag4_ff.side <= tag3_ff.side;
         res4_ff      <= res4_in;
      end
   end

   assign out_tag = tag4_ff;
   assign result  = res4_ff;
endmodule
`default_nettype wire

### tb/sv/fast_inverse_square_root_core_tb.sv
`default_nettype none
module fast_inverse_square_root_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fisr_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int N_RANDOM    = 730;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_x_bits = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_result_bits;

   typedef struct {
      logic [31:0] x;
      bit          known;
      logic [31:0] want;
   } stim_row_type;

   logic [31:0]  want_q[$];
   int           err_count = 0;
   int           cycles = 0;
   bit           stall_rsp = 1'b0;
   bit           stall_done = 1'b0;
   stim_row_type stim[$];

   fast_inverse_square_root_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_x_bits(req_x_bits),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_result_bits(rsp_result_bits)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit is_nan(logic [31:0] a);
      return a[30:23] == 8'hff && a[22:0] != 0;
   endfunction

   // round-to-nearest-even of sign * m * 2^e into single precision
   function automatic logic [31:0] round_pack(bit s, logic [127:0] m, int e);
      int          p, sh, be;
      logic [127:0] kept;
      logic [31:0] base;
      bit          rb, st;
      logic [127:0] mask;
      logic [39:0] sum;
      if (m == 0) return {s, 31'b0};
      p = 0;
      for (int i = 0; i < 128; i++) if (m[i]) p = i;
      be = p + e + 127;
      if (be < 1) begin
         sh = -149 - e;
         base = 0;
      end else begin
         sh = p - 23;
         base = be - 1;
      end
      rb = 1'b0;
      st = 1'b0;
      if (sh <= 0) kept = m << (-sh);
      else if (sh > 120) kept = 0;
      else begin
         kept = m >> sh;
         rb = m[sh-1];
         mask = (128'd1 << (sh - 1)) - 1;
         st = (m & mask) != 0;
      end
      if (rb && (st || kept[0])) kept = kept + 1;
      sum = {8'd0, base} * 40'd8388608 + kept[39:0];
      if (be > 300 || sum >= 40'h7f800000) return {s, 31'h7f800000};
      return {s, sum[30:0]};
   endfunction

   function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
      bit s;
      logic [23:0] ma, mb;
      int ea, eb;
      s = a[31] ^ b[31];
      if (is_nan(a)) return a | QUIET_BIT;
      if (is_nan(b)) return b | QUIET_BIT;
      if (a[30:23] == 8'hff || b[30:23] == 8'hff) begin
         if (a[30:0] == 0 || b[30:0] == 0) return DEFAULT_NAN;
         return {s, 31'h7f800000};
      end
      ma = {a[30:23] != 0, a[22:0]};
      mb = {b[30:23] != 0, b[22:0]};
      ea = (a[30:23] == 0) ? 1 : a[30:23];
      eb = (b[30:23] == 0) ? 1 : b[30:23];
      return round_pack(s, 128'(ma) * 128'(mb), ea + eb - 300);
   endfunction

   function automatic logic [31:0] fp_sub(logic [31:0] a, logic [31:0] b);
      bit sa, sb;
      logic [23:0] ma, mb;
      int ea, eb, d;
      logic [127:0] big, lit;
      if (is_nan(a)) return a | QUIET_BIT;
      if (is_nan(b)) return b | QUIET_BIT;
      sa = a[31];
      sb = ~b[31];
      if (a[30:23] == 8'hff && b[30:23] == 8'hff)
         return (sa == sb) ? a : DEFAULT_NAN;
      if (a[30:23] == 8'hff) return a;
      if (b[30:23] == 8'hff) return {sb, 31'h7f800000};
      if (a[30:0] == 0 && b[30:0] == 0) return {sa & sb, 31'b0};
      ma = {a[30:23] != 0, a[22:0]};
      mb = {b[30:23] != 0, b[22:0]};
      ea = (a[30:23] == 0) ? 1 : a[30:23];
      eb = (b[30:23] == 0) ? 1 : b[30:23];
      if (ea < eb || (ea == eb && ma < mb)) begin
         {sa, sb} = {sb, sa};
         {ma, mb} = {mb, ma};
         {ea, eb} = {eb, ea};
      end
      d = ea - eb;
      if (d > 40) begin
         big = 128'(ma) << 40;
         lit = (mb != 0) ? 128'd1 : 128'd0;
         d = 40;
      end else begin
         big = 128'(ma) << d;
         lit = 128'(mb);
      end
      if (sa == sb) big = big + lit;
      else big = big - lit;
      if (big == 0) return 32'h0;
      return round_pack(sa, big, ea - d - 150);
   endfunction

   function automatic logic [31:0] rsqrt_estimate(logic [31:0] xb);
      logic [31:0] y, xhalf, t1, t2, t3;
      y = MAGIC_CONST - {xb[31], xb[31:1]};
      xhalf = fp_mul(ONE_HALF, xb);
      t1 = fp_mul(xhalf, y);
      t2 = fp_mul(t1, y);
      t3 = fp_sub(THREE_HALVES, t2);
      return fp_mul(y, t3);
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %08h want %08h", what, got, want);
      err_count++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (want_q.size() == 0) report_mismatch("unexpected item", rsp_result_bits, 'x);
         else begin
            logic [31:0] w;
            w = want_q.pop_front();
            if (rsp_result_bits !== w) report_mismatch("result_bits", rsp_result_bits, w);
         end
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] rand_x();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2: v = v;
         3, 4, 5: v[31:23] = {1'b0, 8'($urandom_range(100, 160))};
         6:       v[30:23] = 8'h00;
         7:       v[30:23] = 8'hff;
         8:       v[30:23] = 8'($urandom_range(1, 3));
         default: v[30:23] = 8'($urandom_range(250, 254));
      endcase
      return v;
   endfunction

   task automatic push_row(logic [31:0] x, bit known, logic [31:0] want);
      stim_row_type r;
      r.x = x;
      r.known = known;
      r.want = want;
      stim.push_back(r);
   endtask

   initial begin
      logic [31:0] w;
      int          gap;
      push_row(32'h7fc00000, 1, 32'h7fc00000);
      push_row(32'hffc00000, 1, 32'hffc00000);
      push_row(32'h7f800001, 1, 32'h7fc00001);
      push_row(32'h00000000, 0, 0);
      push_row(32'h80000000, 0, 0);
      push_row(32'h00000001, 0, 0);
      push_row(32'h007fffff, 0, 0);
      push_row(32'h00800000, 0, 0);
      push_row(32'h3f800000, 0, 0);
      push_row(32'h40800000, 0, 0);
      push_row(32'h7f7fffff, 0, 0);
      push_row(32'h7f800000, 0, 0);
      push_row(32'hff800000, 0, 0);
      push_row(32'hbf800000, 0, 0);
      push_row(32'h80000001, 0, 0);
      push_row(32'hffffffff, 0, 0);
      push_row(32'h5f3759df, 0, 0);
      push_row(32'h55555555, 0, 0);
      push_row(32'haaaaaaaa, 0, 0);
      push_row(32'h3e800000, 0, 0);
      for (int i = 0; i < N_RANDOM; i++) push_row(rand_x(), 0, 0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < stim.size(); i++) begin
         gap = gap_len();
         if (i == 200) stall_rsp = 1'b1;
         if (gap > 0 || i == 450) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
            if (i == 450) begin
               do @(negedge clock); while (want_q.size() != 0);
            end
         end
         w = stim[i].known ? stim[i].want : rsqrt_estimate(stim[i].x);
         if (stim[i].known && w !== rsqrt_estimate(stim[i].x))
            report_mismatch("predictor", rsqrt_estimate(stim[i].x), w);
         req_valid <= 1'b1;
         req_x_bits <= stim[i].x;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         want_q.push_back(w);
         @(negedge clock);
      end
      req_valid <= 1'b0;
      while (want_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (err_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      @(negedge clock);
      while (1) begin
         if (stall_rsp && !stall_done) begin
            stall_done = 1'b1;
            for (int i = 0; i < 120; i++) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end
         if ($urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat (gap_len() + 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end
endmodule
`default_nettype wire

### fast_inverse_square_root_core.f
+incdir+sv
sv/fisr_pkg.sv
sv/fisr_fmul.sv
sv/fisr_fsub.sv
sv/fast_inverse_square_root_core.sv
tb/sv/fast_inverse_square_root_core_tb.sv
